>>> hdl/sfta_pkg.sv
// ----------------------------------------------------------------------------
// sfta_pkg
// Shared types and constants of the source flow table.
// ----------------------------------------------------------------------------
package sfta_pkg;

  localparam int TableEntriesDefault = 64;
  localparam logic [15:0] AgeReset = 16'd1800;

  typedef enum logic [1:0] {
    OP_META  = 2'd0,
    OP_DATA  = 2'd1,
    OP_PRUNE = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_INSERTED = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_REJECTED = 3'd3,
    ST_FULL     = 3'd4,
    ST_PRUNED   = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        is_ipv6;
    logic [15:0] src_port;
    logic [63:0] src_addr_high;
    logic [63:0] src_addr_low;
    logic [15:0] stream_id;
    logic [15:0] target_id;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] mapped_target;
    logic [5:0]  entry_slot;
    logic [6:0]  live_entries;
    logic [31:0] ignored_total;
  } rsp_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port;
    logic [15:0] stream;
    logic [15:0] target;
    logic [31:0] stamp;
  } entry_t;

endpackage

>>> hdl/sfta_if.sv
// ----------------------------------------------------------------------------
// sfta_req_if / sfta_rsp_if
// Valid/ready channels for request and result transactions.
// ----------------------------------------------------------------------------
interface sfta_req_if;
  import sfta_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface sfta_rsp_if;
  import sfta_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> hdl/source_flow_table_with_aging.sv
// Lookup walks live entries one per cycle for each meta or data transaction;
// prune reads each entry and writes back only the entries that it keeps,
// compacting the table toward slot 0.
// One transaction is in flight at a time; a new transaction is accepted only
// after the result has been taken. Synchronous reset empties the table
// by clearing the entry count; memory contents are not cleared.
// ----------------------------------------------------------------------------
// source_flow_table_with_aging
// Flow table keyed by IPv6 source, port and stream, with age-based prune.
// ----------------------------------------------------------------------------
module source_flow_table_with_aging #(
  parameter int TABLE_ENTRIES = sfta_pkg::TableEntriesDefault
) (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic [15:0] cfg_wdata,
  sfta_req_if.sink   req,
  sfta_rsp_if.source rsp
);
  import sfta_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_UPD   = 6'b000100,
    S_PREAD = 6'b001000,
    S_PWR   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  entry_t mem [TABLE_ENTRIES];
  entry_t rd;

  state_t state;
  req_t   cur;
  logic [15:0] max_age;
  logic [CW-1:0] count;
  logic [31:0] ignored;
  logic [CW-1:0] rptr;
  logic [CW-1:0] wptr;
  logic rd_valid;
  logic [AW-1:0] rd_slot;
  logic [AW-1:0] hit_slot;
  logic fresh;
  logic out_valid;
  rsp_t out_data;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;

  logic key_match;
  logic keep;
  logic accept;

  assign accept = req.valid && req.ready;
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data = out_data;

  assign key_match = rd.addr_high == cur.src_addr_high && rd.addr_low == cur.src_addr_low
                  && rd.port == cur.src_port && rd.stream == cur.stream_id;
  assign keep = ({1'b0, rd.stamp} + {17'd0, max_age}) >= {1'b0, cur.now_seconds};

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd <= mem[raddr];
  end

  always_comb begin
    we = 1'b0;
    waddr = rd_slot;
    wdata = rd;
    raddr = rptr[AW-1:0];
    // hold the matched entry on the read port for the update
    if (state == S_SCAN && rd_valid && key_match) raddr = rd_slot;
    if (state == S_UPD) begin
      waddr = hit_slot;
      wdata.addr_high = cur.src_addr_high;
      wdata.addr_low = cur.src_addr_low;
      wdata.port = cur.src_port;
      wdata.stream = cur.stream_id;
      if (fresh) begin
        wdata.target = 16'd0;
        wdata.stamp = 32'd0;
      end
      if (opcode_t'(cur.opcode) == OP_META) begin
        wdata.target = cur.target_id;
        wdata.stamp = cur.now_seconds;
        we = 1'b1;
      end else if (fresh) begin
        we = 1'b1;
      end else if (rd.target != 16'd0) begin
        wdata.stamp = cur.now_seconds;
        we = 1'b1;
      end
    end else if (state == S_PWR) begin
      waddr = wptr[AW-1:0];
      wdata = rd;
      we = keep && (wptr != CW'(rd_slot));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_age <= AgeReset;
      count <= '0;
      ignored <= '0;
      out_valid <= 1'b0;
      rptr <= '0;
      wptr <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cfg_we) max_age <= cfg_wdata;
      if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cur <= req.data;
            rptr <= '0;
            wptr <= '0;
            rd_valid <= 1'b0;
            if (opcode_t'(req.data.opcode) == OP_PRUNE) begin
              state <= S_PREAD;
            end else if (req.data.opcode[1] || !req.data.is_ipv6 ||
                         (opcode_t'(req.data.opcode) == OP_META &&
                          req.data.stream_id == 16'd0)) begin
              out_data <= '{ST_REJECTED, 16'd0, 6'd0, 7'(count), ignored};
              out_valid <= 1'b1;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd holds entry rd_slot when rd_valid
          if (rd_valid && key_match) begin
            hit_slot <= rd_slot;
            fresh <= 1'b0;
            state <= S_UPD;
          end else if (rptr >= count) begin
            if (!rd_valid || rptr == count) begin
              if (count == CW'(TABLE_ENTRIES)) begin
                out_data <= '{ST_FULL, 16'd0, 6'd0, 7'(count), ignored};
                out_valid <= 1'b1;
                state <= S_IDLE;
              end else begin
                hit_slot <= count[AW-1:0];
                fresh <= 1'b1;
                count <= count + 1'b1;
                state <= S_UPD;
              end
            end
            rd_valid <= 1'b0;
          end else begin
            rd_slot <= rptr[AW-1:0];
            rd_valid <= 1'b1;
            rptr <= rptr + 1'b1;
          end
        end
        S_UPD: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
          if (opcode_t'(cur.opcode) == OP_META) begin
            out_data <= '{fresh ? ST_INSERTED : ST_FOUND, cur.target_id,
                          6'(hit_slot), 7'(count), ignored};
          end else if (fresh || rd.target == 16'd0) begin
            out_data <= '{ST_IGNORED, 16'd0, 6'(hit_slot), 7'(count),
                          (ignored == '1) ? ignored : ignored + 1'b1};
            if (ignored != '1) ignored <= ignored + 1'b1;
          end else begin
            out_data <= '{ST_FOUND, rd.target, 6'(hit_slot), 7'(count), ignored};
          end
        end
        S_PREAD: begin
          if (rptr >= count) begin
            count <= wptr;
            out_data <= '{ST_PRUNED, 16'd0, 6'd0, 7'(wptr), ignored};
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            rd_slot <= rptr[AW-1:0];
            rptr <= rptr + 1'b1;
            state <= S_PWR;
          end
        end
        S_PWR: begin
          if (keep) wptr <= wptr + 1'b1;
          state <= S_PREAD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Only the scan of the last entry may leave rd_valid with rptr at count.
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
  a_wptr_le_rptr: assert property (@(posedge clk) disable iff (rst)
    wptr <= rptr) else $error("prune write passed read");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != S_IDLE || out_valid) else $error("accept without work");
  a_ign_mono: assert property (@(posedge clk) disable iff (rst)
    ignored >= $past(ignored) || $past(rst)) else $error("ignored count fell");
endmodule
